// ===== rtl/fas_pkg.sv =====
package fas_pkg;

    localparam int MAX_FRAMES_DEF = 64;

    localparam int DUR_W      = 16;
    localparam int SPR_W      = 16;
    localparam int TBL_W      = DUR_W + SPR_W;
    localparam int TIME_W     = 34;
    localparam int PROD_W     = 28;
    localparam int EVT_W      = 8;
    localparam int FNUM_W     = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [11:0] SPEED_ONE       = 12'd256;
    localparam logic [6:0]  FRAME_COUNT_RST = 7'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PING_PONG   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED       = 3'd4;

    typedef enum logic [2:0] {
        CMD_TICK,
        CMD_PLAY,
        CMD_PAUSE,
        CMD_UNPAUSE,
        CMD_STOP,
        CMD_RESET,
        CMD_SET_FRAME,
        CMD_LOAD
    } cmd_t;

    typedef struct packed {
        logic [2:0]        command;
        logic [15:0]       elapsed;
        logic [FNUM_W-1:0] frame_number;
        logic              option_flag;
        logic [DUR_W-1:0]  entry_duration;
        logic [SPR_W-1:0]  entry_sprite;
    } in_item_t;

    typedef struct packed {
        logic              accepted;
        logic              range_error;
        logic [EVT_W-1:0]  frames_ended;
        logic [EVT_W-1:0]  frames_begun;
        logic [EVT_W-1:0]  loops;
        logic              completed;
        logic              stopped;
        logic [FNUM_W-1:0] frame_position;
        logic [SPR_W-1:0]  sprite_index;
        logic              animating;
        logic              paused;
    } out_item_t;

    typedef struct packed {
        logic [6:0]  frame_count;
        logic        loop_enable;
        logic        ping_pong_enable;
        logic        reverse_start;
        logic [11:0] speed;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic slot_free;
    } seq_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic speed_reload;
    } seq_stat_t;

endpackage

// ===== rtl/fas_table.sv =====
module fas_table
    import fas_pkg::*;
#(
    parameter int DEPTH = MAX_FRAMES_DEF,
    localparam int AW = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [TBL_W-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [TBL_W-1:0] rdata
);

    logic [TBL_W-1:0] mem_array [DEPTH];
    logic [TBL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/fas_seq.sv =====
module fas_seq
    import fas_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    localparam int AW = $clog2(MAX_FRAMES)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  seq_ctrl_t        ctrl,
    input  cfg_t             cfg,
    input  in_item_t         item,
    output seq_stat_t        stat,
    output out_item_t        result,
    output logic             tbl_we,
    output logic [AW-1:0]    tbl_waddr,
    output logic [TBL_W-1:0] tbl_wdata,
    output logic             tbl_re,
    output logic [AW-1:0]    tbl_raddr,
    input  logic [TBL_W-1:0] tbl_rdata
);

    localparam int CW = $clog2(MAX_FRAMES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SUB,
        S_ADV,
        S_LOAD,
        S_FETCH,
        S_DONE
    } state_t;

    state_t             state_reg,    state_next;
    logic [AW-1:0]      position_reg, position_next;
    logic               backward_reg, backward_next;
    logic               running_reg,  running_next;
    logic               halted_reg,   halted_next;
    logic [TIME_W-1:0]  tl_reg,       tl_next;
    logic [PROD_W-1:0]  prod_reg,     prod_next;
    logic               walk_reg,     walk_next;
    logic               acc_reg,      acc_next;
    logic               rerr_reg,     rerr_next;
    logic [EVT_W-1:0]   ends_reg,     ends_next;
    logic [EVT_W-1:0]   begun_reg,    begun_next;
    logic [EVT_W-1:0]   loops_reg,    loops_next;
    logic               compl_reg,    compl_next;
    logic               stop_reg,     stop_next;

    logic [CW-1:0]      cnt;
    logic [AW-1:0]      last;
    logic               fnum_ok;
    logic               addr_ok;
    logic [AW-1:0]      fnum_addr;

    logic [AW-1:0]      pos_c;
    logic               at_end;
    logic [AW-1:0]      adv_np;
    logic               adv_back;
    logic               adv_loop;
    logic               adv_fail;

    logic [DUR_W-1:0]   rd_dur;
    logic [TIME_W-1:0]  rd_q8;
    logic [TIME_W-1:0]  tl_sub;
    logic [TIME_W-1:0]  tl_sum;

    function automatic logic [EVT_W-1:0] sat_inc(input logic [EVT_W-1:0] v);
        return (v == {EVT_W{1'b1}}) ? v : v + EVT_W'(1);
    endfunction

    // frames in use: zero acts as one, clamp to table depth
    always_comb
    begin
        if (cfg.frame_count == '0)
        begin
            cnt = CW'(1);
        end
        else if (32'(cfg.frame_count) > 32'(MAX_FRAMES))
        begin
            cnt = CW'(MAX_FRAMES);
        end
        else
        begin
            cnt = CW'(cfg.frame_count);
        end
    end

    assign last      = AW'(cnt - CW'(1));
    assign fnum_ok   = 32'(item.frame_number) < 32'(cnt);
    assign addr_ok   = 32'(item.frame_number) < 32'(MAX_FRAMES);
    assign fnum_addr = AW'(item.frame_number);

    // one step of the walk: wrap, bounce or run off the end
    always_comb
    begin
        pos_c    = (CW'(position_reg) >= cnt) ? last : position_reg;
        at_end   = backward_reg ? (pos_c == '0) : (pos_c == last);
        adv_np   = pos_c;
        adv_back = backward_reg;
        adv_loop = 1'b0;
        adv_fail = 1'b0;
        if (!at_end)
        begin
            adv_np = backward_reg ? pos_c - AW'(1) : pos_c + AW'(1);
        end
        else if (cfg.loop_enable)
        begin
            adv_loop = 1'b1;
            if (cfg.ping_pong_enable)
            begin
                adv_back = !backward_reg;
                if (!backward_reg)
                begin
                    adv_np = (pos_c == '0) ? '0 : pos_c - AW'(1);
                end
                else
                begin
                    adv_np = (last == '0) ? '0 : AW'(1);
                end
            end
            else
            begin
                adv_np = backward_reg ? last : '0;
            end
        end
        else
        begin
            adv_fail = 1'b1;
        end
    end

    assign rd_dur = (tbl_rdata[TBL_W-1 -: DUR_W] == '0) ? DUR_W'(1)
                                                        : tbl_rdata[TBL_W-1 -: DUR_W];
    assign rd_q8  = TIME_W'({rd_dur, 8'h00});
    assign tl_sub = tl_reg - TIME_W'(prod_reg);
    assign tl_sum = rd_q8 + (walk_reg ? tl_reg : '0);

    always_comb
    begin
        state_next    = state_reg;
        position_next = position_reg;
        backward_next = backward_reg;
        running_next  = running_reg;
        halted_next   = halted_reg;
        tl_next       = tl_reg;
        prod_next     = prod_reg;
        walk_next     = walk_reg;
        acc_next      = acc_reg;
        rerr_next     = rerr_reg;
        ends_next     = ends_reg;
        begun_next    = begun_reg;
        loops_next    = loops_reg;
        compl_next    = compl_reg;
        stop_next     = stop_reg;

        tbl_we        = 1'b0;
        tbl_waddr     = fnum_addr;
        tbl_wdata     = {((item.entry_duration == '0) ? DUR_W'(1) : item.entry_duration),
                         item.entry_sprite};
        tbl_re        = 1'b0;
        tbl_raddr     = position_reg;

        stat.busy         = (state_reg != S_IDLE);
        stat.done         = 1'b0;
        stat.speed_reload = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (ctrl.start)
                begin
                    acc_next   = 1'b0;
                    rerr_next  = 1'b0;
                    ends_next  = '0;
                    begun_next = '0;
                    loops_next = '0;
                    compl_next = 1'b0;
                    stop_next  = 1'b0;
                    walk_next  = 1'b0;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_FETCH;
                prod_next  = PROD_W'(item.elapsed) * PROD_W'(cfg.speed);
                unique case (cmd_t'(item.command))
                    CMD_TICK:
                    begin
                        if (running_reg && !halted_reg)
                        begin
                            acc_next   = 1'b1;
                            walk_next  = 1'b1;
                            state_next = S_SUB;
                        end
                    end
                    CMD_PLAY:
                    begin
                        if (!fnum_ok)
                        begin
                            rerr_next = 1'b1;
                        end
                        else if (!running_reg)
                        begin
                            running_next  = 1'b1;
                            position_next = fnum_addr;
                            acc_next      = 1'b1;
                            tbl_re        = 1'b1;
                            tbl_raddr     = fnum_addr;
                            state_next    = S_LOAD;
                        end
                    end
                    CMD_PAUSE:
                    begin
                        if (running_reg && !halted_reg)
                        begin
                            halted_next = 1'b1;
                            acc_next    = 1'b1;
                            if (item.option_flag)
                            begin
                                tbl_re     = 1'b1;
                                tbl_raddr  = position_reg;
                                state_next = S_LOAD;
                            end
                        end
                    end
                    CMD_UNPAUSE:
                    begin
                        if (running_reg && halted_reg)
                        begin
                            halted_next = 1'b0;
                            acc_next    = 1'b1;
                            if (item.option_flag)
                            begin
                                state_next = S_ADV;
                            end
                        end
                    end
                    CMD_STOP:
                    begin
                        if (running_reg)
                        begin
                            running_next = 1'b0;
                            halted_next  = 1'b1;
                            stop_next    = 1'b1;
                            acc_next     = 1'b1;
                        end
                    end
                    CMD_RESET:
                    begin
                        backward_next     = cfg.reverse_start;
                        running_next      = 1'b0;
                        halted_next       = 1'b1;
                        stat.speed_reload = 1'b1;
                        position_next     = cfg.reverse_start ? last : '0;
                        acc_next          = 1'b1;
                        tbl_re            = 1'b1;
                        tbl_raddr         = cfg.reverse_start ? last : '0;
                        state_next        = S_LOAD;
                    end
                    CMD_SET_FRAME:
                    begin
                        if (!fnum_ok)
                        begin
                            rerr_next = 1'b1;
                        end
                        else
                        begin
                            position_next = fnum_addr;
                            begun_next    = sat_inc(begun_reg);
                            acc_next      = 1'b1;
                            tbl_re        = 1'b1;
                            tbl_raddr     = fnum_addr;
                            state_next    = S_LOAD;
                        end
                    end
                    CMD_LOAD:
                    begin
                        if (!addr_ok)
                        begin
                            rerr_next = 1'b1;
                        end
                        else
                        begin
                            tbl_we   = 1'b1;
                            acc_next = 1'b1;
                        end
                    end
                endcase
            end

            S_SUB:
            begin
                tl_next = tl_sub;
                if (tl_sub[TIME_W-1] || (tl_sub == '0))
                begin
                    state_next = S_ADV;
                end
                else
                begin
                    state_next = S_FETCH;
                end
            end

            S_ADV:
            begin
                if (walk_reg)
                begin
                    ends_next = sat_inc(ends_reg);
                end
                if (adv_fail)
                begin
                    // run off the end: hold the leftover time
                    position_next = pos_c;
                    running_next  = 1'b0;
                    halted_next   = 1'b1;
                    compl_next    = 1'b1;
                    state_next    = S_FETCH;
                end
                else
                begin
                    position_next = adv_np;
                    backward_next = adv_back;
                    begun_next    = sat_inc(begun_reg);
                    if (adv_loop)
                    begin
                        loops_next = sat_inc(loops_reg);
                    end
                    tbl_re     = 1'b1;
                    tbl_raddr  = adv_np;
                    state_next = S_LOAD;
                end
            end

            S_LOAD:
            begin
                // carry the overshoot into the new frame while walking
                tl_next = tl_sum;
                if (walk_reg && (tl_sum[TIME_W-1] || (tl_sum == '0)))
                begin
                    state_next = S_ADV;
                end
                else
                begin
                    state_next = S_FETCH;
                end
            end

            S_FETCH:
            begin
                tbl_re     = 1'b1;
                tbl_raddr  = position_reg;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (ctrl.slot_free)
                begin
                    stat.done  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result.accepted       = acc_reg;
        result.range_error    = rerr_reg;
        result.frames_ended   = ends_reg;
        result.frames_begun   = begun_reg;
        result.loops          = loops_reg;
        result.completed      = compl_reg;
        result.stopped        = stop_reg;
        result.frame_position = FNUM_W'(position_reg);
        result.sprite_index   = tbl_rdata[SPR_W-1:0];
        result.animating      = running_reg;
        result.paused         = halted_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            position_reg <= '0;
            backward_reg <= 1'b0;
            running_reg  <= 1'b0;
            halted_reg   <= 1'b0;
            tl_reg       <= '0;
            walk_reg     <= 1'b0;
            acc_reg      <= 1'b0;
            rerr_reg     <= 1'b0;
            ends_reg     <= '0;
            begun_reg    <= '0;
            loops_reg    <= '0;
            compl_reg    <= 1'b0;
            stop_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            position_reg <= position_next;
            backward_reg <= backward_next;
            running_reg  <= running_next;
            halted_reg   <= halted_next;
            tl_reg       <= tl_next;
            walk_reg     <= walk_next;
            acc_reg      <= acc_next;
            rerr_reg     <= rerr_next;
            ends_reg     <= ends_next;
            begun_reg    <= begun_next;
            loops_reg    <= loops_next;
            compl_reg    <= compl_next;
            stop_reg     <= stop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    a_complete_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADV && adv_fail) |=> (!running_reg && halted_reg))
        else $error("completion did not halt the animation");

    a_acc_or_rerr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> !(acc_reg && rerr_reg))
        else $error("word both accepted and range error");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD && walk_reg) |-> (CW'(position_reg) < cnt))
        else $error("walk left the frames in use");

    a_write_then_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_we |=> (state_reg == S_FETCH))
        else $error("table write not followed by fetch");

endmodule

// ===== rtl/frame_animation_sequencer_core.sv =====
// Frame animation sequencer. Each word on the input channel is one command
// (tick, play, pause, unpause, stop, reset, set frame, load table entry) and
// produces exactly one result word. Commands are handled one at a time. Play,
// set frame, reset, pause-with-reload and unpause-with-advance also load the
// new frame's duration from the table (unpause-with-advance does not when the
// advance runs off the end of the table). A tick performs one frame advance for
// each frame it passes; each advance reads the next frame from the table memory
// and checks the carried-over time, so a large elapsed value against short
// frames walks for a long time. A result word that is not taken holds the
// block before it can finish the next command. The frame table is a synchronous
// memory with one write and one read port holding duration and sprite per
// entry; reading an entry that was never loaded gives an unspecified sprite and
// duration. Configuration writes are dropped in the cycle in which a reset
// command reloads the speed, and must only be issued while no command is in
// flight.
module frame_animation_sequencer_core
    import fas_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_FRAMES);

    cfg_t             cfg_reg;
    in_item_t         in_reg;
    out_item_t        out_reg;
    logic             out_valid_reg;

    seq_ctrl_t        ctrl;
    seq_stat_t        stat;
    out_item_t        result;

    logic             tbl_we;
    logic [AW-1:0]    tbl_waddr;
    logic [TBL_W-1:0] tbl_wdata;
    logic             tbl_re;
    logic [AW-1:0]    tbl_raddr;
    logic [TBL_W-1:0] tbl_rdata;

    assign in_ready       = !stat.busy;
    assign ctrl.start     = in_valid && in_ready;
    assign ctrl.slot_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_count      <= FRAME_COUNT_RST;
            cfg_reg.loop_enable      <= 1'b0;
            cfg_reg.ping_pong_enable <= 1'b0;
            cfg_reg.reverse_start    <= 1'b0;
            cfg_reg.speed            <= SPEED_ONE;
        end
        else if (stat.speed_reload)
        begin
            cfg_reg.speed <= SPEED_ONE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_COUNT: cfg_reg.frame_count      <= cfg_data[6:0];
                CFG_LOOP:        cfg_reg.loop_enable      <= cfg_data[0];
                CFG_PING_PONG:   cfg_reg.ping_pong_enable <= cfg_data[0];
                CFG_REVERSE:     cfg_reg.reverse_start    <= cfg_data[0];
                CFG_SPEED:       cfg_reg.speed            <= cfg_data[11:0];
                default:         ;
            endcase
        end
    end

    // hold the command word for the whole walk
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            in_reg <= in_data;
        end
        if (stat.done)
        begin
            out_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stat.done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    fas_seq #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .cfg       (cfg_reg),
        .item      (in_reg),
        .stat      (stat),
        .result    (result),
        .tbl_we    (tbl_we),
        .tbl_waddr (tbl_waddr),
        .tbl_wdata (tbl_wdata),
        .tbl_re    (tbl_re),
        .tbl_raddr (tbl_raddr),
        .tbl_rdata (tbl_rdata)
    );

    fas_table #(
        .DEPTH (MAX_FRAMES)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fas_pkg::*;

    localparam int WALK_MAX     = 400;
    localparam int RANDOM_WORDS = 300;
    localparam int CYCLE_LIMIT  = 3_000_000;

    typedef struct {
        int     pos;
        bit     back;
        bit     run;
        bit     halt;
        longint tleft;
    } anim_t;

    typedef struct {
        in_item_t  word;
        out_item_t result;
    } pending_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_FRAME_COUNT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    frame_animation_sequencer_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // sequencer mirror: table, animation state, register copy
    logic [DUR_W-1:0] dur_mem [MAX_FRAMES_DEF];
    logic [SPR_W-1:0] spr_mem [MAX_FRAMES_DEF];
    anim_t anim;
    cfg_t  regs;
    int    n_ended;
    int    n_begun;
    int    n_loops;
    bit    ran_off;

    pending_t  cmd_backlog[$];
    out_item_t due_results[$];
    pending_t  next_up;
    out_item_t held_result;
    int        send_gap;
    int        result_stall;
    bit        quiet;
    int        errors;
    int        n_results;
    int unsigned cycles = 0;

    function automatic int frames_in_use();
        if (regs.frame_count == 0)
            return 1;
        if (regs.frame_count > MAX_FRAMES_DEF)
            return MAX_FRAMES_DEF;
        return int'(regs.frame_count);
    endfunction

    function automatic longint dur_q8(int idx);
        int d;
        d = int'(dur_mem[idx[FNUM_W-1:0]]);
        if (d == 0)
            d = 1;
        return longint'(d) * 256;
    endfunction

    function automatic logic [EVT_W-1:0] sat8(int v);
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    // move one frame on; return 0 when the animation runs off an end
    function automatic bit step_frame();
        int cnt;
        int p;
        int dir;
        int np;
        cnt = frames_in_use();
        p = anim.pos;
        dir = anim.back ? -1 : 1;
        if (p >= cnt)
            p = cnt - 1;
        np = p + dir;
        if (np < 0 || np >= cnt)
        begin
            if (regs.loop_enable)
            begin
                if (regs.ping_pong_enable)
                begin
                    dir = -dir;
                    anim.back = !anim.back;
                    np += 2 * dir;
                    // clamp so a single frame stays on frame 0
                    if (np < 0)
                        np = 0;
                    if (np >= cnt)
                        np = cnt - 1;
                end
                else
                    np = (dir < 0) ? cnt - 1 : 0;
                n_loops++;
            end
            else
            begin
                anim.pos = p;
                anim.run = 1'b0;
                anim.halt = 1'b1;
                ran_off = 1'b1;
                return 1'b0;
            end
        end
        anim.pos = np;
        anim.tleft = dur_q8(np);
        n_begun++;
        return 1'b1;
    endfunction

    function automatic out_item_t run_command(in_item_t it);
        out_item_t r;
        longint t;
        longint over;
        bit took;
        bit bad_frame;
        bit stop_ev;
        took = 1'b0;
        bad_frame = 1'b0;
        stop_ev = 1'b0;
        n_ended = 0;
        n_begun = 0;
        n_loops = 0;
        ran_off = 1'b0;
        case (cmd_t'(it.command))
            CMD_TICK:
                if (anim.run && !anim.halt)
                begin
                    t = anim.tleft - longint'(it.elapsed) * longint'(regs.speed);
                    took = 1'b1;
                    // carry the overshoot into each new frame
                    while (t <= 0)
                    begin
                        over = -t;
                        n_ended++;
                        if (!step_frame())
                            break;
                        t = anim.tleft - over;
                    end
                    anim.tleft = t;
                end
            CMD_PLAY:
                if (it.frame_number >= frames_in_use())
                    bad_frame = 1'b1;
                else if (!anim.run)
                begin
                    anim.run = 1'b1;
                    anim.pos = int'(it.frame_number);
                    anim.tleft = dur_q8(anim.pos);
                    took = 1'b1;
                end
            CMD_PAUSE:
                if (anim.run && !anim.halt)
                begin
                    anim.halt = 1'b1;
                    if (it.option_flag)
                        anim.tleft = dur_q8(anim.pos);
                    took = 1'b1;
                end
            CMD_UNPAUSE:
                if (anim.run && anim.halt)
                begin
                    anim.halt = 1'b0;
                    if (it.option_flag)
                        void'(step_frame());
                    took = 1'b1;
                end
            CMD_STOP:
                if (anim.run)
                begin
                    anim.run = 1'b0;
                    anim.halt = 1'b1;
                    stop_ev = 1'b1;
                    took = 1'b1;
                end
            CMD_RESET:
            begin
                anim.back = regs.reverse_start;
                anim.run = 1'b0;
                anim.halt = 1'b1;
                regs.speed = SPEED_ONE;
                anim.pos = anim.back ? frames_in_use() - 1 : 0;
                anim.tleft = dur_q8(anim.pos);
                took = 1'b1;
            end
            CMD_SET_FRAME:
                if (it.frame_number >= frames_in_use())
                    bad_frame = 1'b1;
                else
                begin
                    anim.pos = int'(it.frame_number);
                    anim.tleft = dur_q8(anim.pos);
                    n_begun++;
                    took = 1'b1;
                end
            default:
            begin
                dur_mem[it.frame_number] = (it.entry_duration == 0) ? 16'd1 : it.entry_duration;
                spr_mem[it.frame_number] = it.entry_sprite;
                took = 1'b1;
            end
        endcase
        r.accepted = took;
        r.range_error = bad_frame;
        r.frames_ended = sat8(n_ended);
        r.frames_begun = sat8(n_begun);
        r.loops = sat8(n_loops);
        r.completed = ran_off;
        r.stopped = stop_ev;
        r.frame_position = anim.pos[FNUM_W-1:0];
        r.sprite_index = spr_mem[anim.pos[FNUM_W-1:0]];
        r.animating = anim.run;
        r.paused = anim.halt;
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic in_item_t make_word(cmd_t c, int f, bit o, int e);
        logic [63:0] raw;
        in_item_t w;
        raw = {$urandom, $urandom};
        w = raw[$bits(in_item_t)-1:0];
        w.command = c;
        w.frame_number = f[FNUM_W-1:0];
        w.option_flag = o;
        if (c == CMD_TICK)
            w.elapsed = e[15:0];
        return w;
    endfunction

    function automatic in_item_t load_word(int f, int d, int s);
        in_item_t w;
        w = make_word(CMD_LOAD, f, 1'($urandom_range(0, 1)), 0);
        w.entry_duration = d[DUR_W-1:0];
        w.entry_sprite = s[SPR_W-1:0];
        return w;
    endfunction

    // mostly well-formed play/tick/pause traffic, some noise
    function automatic in_item_t next_word();
        in_item_t w;
        int roll;
        int cnt;
        int f;
        cmd_t c;
        cnt = frames_in_use();
        roll = $urandom_range(0, 99);
        if (roll < 15)
            c = cmd_t'($urandom_range(0, 7));
        else if (!anim.run)
            c = (roll < 75) ? CMD_PLAY : (roll < 85) ? CMD_RESET :
                (roll < 92) ? CMD_LOAD : CMD_SET_FRAME;
        else if (anim.halt)
            c = (roll < 75) ? CMD_UNPAUSE : (roll < 83) ? CMD_STOP :
                (roll < 91) ? CMD_SET_FRAME : CMD_LOAD;
        else
            c = (roll < 70) ? CMD_TICK : (roll < 78) ? CMD_PAUSE :
                (roll < 86) ? CMD_SET_FRAME : (roll < 93) ? CMD_LOAD : CMD_STOP;
        f = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, cnt - 1);
        w = make_word(c, f, 1'($urandom_range(0, 1)),
                      $urandom_range(0, 65535) >> $urandom_range(0, 15));
        if (c == CMD_LOAD)
            w.entry_duration = ($urandom_range(0, 1) == 0) ? DUR_W'($urandom_range(1, 8))
                                                            : DUR_W'($urandom_range(0, 65535));
        return w;
    endfunction

    // predict and queue one word; shorten ticks whose walk would run too long
    task automatic send(in_item_t it);
        pending_t p;
        anim_t keep;
        keep = anim;
        p.word = it;
        p.result = run_command(it);
        while (n_ended > WALK_MAX)
        begin
            anim = keep;
            it.elapsed = it.elapsed >> 1;
            p.word = it;
            p.result = run_command(it);
        end
        cmd_backlog.push_back(p);
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (cmd_backlog.size() != 0 || in_valid || due_results.size() != 0);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        logic [CFG_DATA_W-1:0] d;
        int w;
        case (idx)
            CFG_FRAME_COUNT: w = 7;
            CFG_SPEED:       w = 12;
            default:         w = 1;
        endcase
        // junk above the register width must be dropped
        d = CFG_DATA_W'($urandom);
        for (int b = 0; b < w; b++)
            d[b] = val[b];
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_FRAME_COUNT: regs.frame_count = d[6:0];
            CFG_LOOP:        regs.loop_enable = d[0];
            CFG_PING_PONG:   regs.ping_pong_enable = d[0];
            CFG_REVERSE:     regs.reverse_start = d[0];
            CFG_SPEED:       regs.speed = d[11:0];
            default:         ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                due_results.push_back(held_result);
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (cmd_backlog.size() != 0)
                begin
                    next_up = cmd_backlog.pop_front();
                    in_data <= next_up.word;
                    held_result <= next_up.result;
                    in_valid <= 1'b1;
                    send_gap <= pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    task automatic cmp(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch in word %0d, %s: expected %0h, got %0h",
                         n_results, name, want, got);
        end
    endtask

    task automatic check_word(out_item_t got);
        out_item_t want;
        if (due_results.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("result word %0d arrived with nothing outstanding", n_results);
        end
        else
        begin
            want = due_results.pop_front();
            cmp("accepted", 32'(want.accepted), 32'(got.accepted));
            cmp("range_error", 32'(want.range_error), 32'(got.range_error));
            cmp("frames_ended", 32'(want.frames_ended), 32'(got.frames_ended));
            cmp("frames_begun", 32'(want.frames_begun), 32'(got.frames_begun));
            cmp("loops", 32'(want.loops), 32'(got.loops));
            cmp("completed", 32'(want.completed), 32'(got.completed));
            cmp("stopped", 32'(want.stopped), 32'(got.stopped));
            cmp("frame_position", 32'(want.frame_position), 32'(got.frame_position));
            cmp("sprite_index", 32'(want.sprite_index), 32'(got.sprite_index));
            cmp("animating", 32'(want.animating), 32'(got.animating));
            cmp("paused", 32'(want.paused), 32'(got.paused));
        end
        n_results++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            result_stall <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_word(out_data);
            if (result_stall > 0)
            begin
                result_stall <= result_stall - 1;
                out_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                result_stall <= pick_gap();
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int d;
        int s;
        int live;
        int fc;
        int spd;
        anim = '{0, 1'b0, 1'b0, 1'b0, 0};
        regs = '{FRAME_COUNT_RST, 1'b0, 1'b0, 1'b0, SPEED_ONE};
        quiet = 1'b0;
        errors = 0;
        n_results = 0;
        live = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // fill the whole table first so no read ever hits an unloaded entry
        for (int i = 0; i < MAX_FRAMES_DEF; i++)
        begin
            d = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 6);
            s = $urandom_range(0, 65535);
            if (i == 5)
                d = 0;
            if (i == MAX_FRAMES_DEF - 1)
            begin
                d = 16'hFFFF;
                s = 16'hFFFF;
            end
            if (i == MAX_FRAMES_DEF - 2)
                s = 0;
            send(load_word(i, d, s));
        end

        // refused commands while idle, range errors, run off the end of one frame
        send(make_word(CMD_TICK, 0, 1'b0, 100));
        send(make_word(CMD_PAUSE, 0, 1'b1, 0));
        send(make_word(CMD_UNPAUSE, 0, 1'b1, 0));
        send(make_word(CMD_STOP, 0, 1'b0, 0));
        send(make_word(CMD_PLAY, 1, 1'b0, 0));
        send(make_word(CMD_SET_FRAME, 63, 1'b0, 0));
        send(make_word(CMD_PLAY, 0, 1'b0, 0));
        send(make_word(CMD_PLAY, 0, 1'b0, 0));
        send(make_word(CMD_TICK, 0, 1'b0, 16'hFFFF));
        send(make_word(CMD_TICK, 0, 1'b0, 1));
        drain();

        // one-frame ping-pong, reverse start, play left halted after reset
        write_reg(CFG_LOOP, 1);
        write_reg(CFG_PING_PONG, 1);
        write_reg(CFG_REVERSE, 1);
        send(make_word(CMD_RESET, 0, 1'b0, 0));
        send(make_word(CMD_PLAY, 0, 1'b0, 0));
        send(make_word(CMD_TICK, 0, 1'b0, 5));
        send(make_word(CMD_UNPAUSE, 0, 1'b1, 0));
        send(make_word(CMD_TICK, 0, 1'b0, 16'hFFFF));
        send(make_word(CMD_PAUSE, 0, 1'b1, 0));
        send(make_word(CMD_UNPAUSE, 0, 1'b0, 0));
        send(make_word(CMD_STOP, 0, 1'b0, 0));
        drain();

        // full table, reset drops speed back to 1.0, wrap at the last frame
        write_reg(CFG_FRAME_COUNT, MAX_FRAMES_DEF);
        write_reg(CFG_PING_PONG, 0);
        write_reg(CFG_REVERSE, 0);
        write_reg(CFG_SPEED, 4095);
        send(make_word(CMD_RESET, 0, 1'b0, 0));
        send(make_word(CMD_SET_FRAME, 63, 1'b0, 0));
        send(make_word(CMD_PLAY, 63, 1'b0, 0));
        send(make_word(CMD_UNPAUSE, 0, 1'b0, 0));
        send(make_word(CMD_TICK, 0, 1'b0, 16'hFFFF));
        drain();

        // short frames so one tick saturates the frames-ended and frames-begun counts
        write_reg(CFG_FRAME_COUNT, 4);
        write_reg(CFG_SPEED, 256);
        for (int i = 0; i < 4; i++)
            send(load_word(i, 1, $urandom_range(0, 65535)));
        send(make_word(CMD_STOP, 0, 1'b0, 0));
        send(make_word(CMD_PLAY, 0, 1'b0, 0));
        send(make_word(CMD_UNPAUSE, 0, 1'b0, 0));
        send(make_word(CMD_TICK, 0, 1'b0, 300));
        drain();

        while (live < RANDOM_WORDS)
        begin
            case ($urandom_range(0, 5))
                0:       fc = 1;
                1:       fc = MAX_FRAMES_DEF;
                2:       fc = 0;
                3:       fc = $urandom_range(MAX_FRAMES_DEF + 1, 127);
                default: fc = $urandom_range(2, 16);
            endcase
            case ($urandom_range(0, 5))
                0:       spd = 0;
                1:       spd = 4095;
                2, 3:    spd = 256;
                default: spd = $urandom_range(1, 1023);
            endcase
            write_reg(CFG_FRAME_COUNT, fc);
            write_reg(CFG_LOOP, ($urandom_range(0, 3) != 0));
            write_reg(CFG_PING_PONG, $urandom_range(0, 1));
            write_reg(CFG_REVERSE, $urandom_range(0, 1));
            write_reg(CFG_SPEED, spd);
            quiet = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(20, 50))
            begin
                send(next_word());
                live++;
            end
            drain();
        end

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
